@@ rtl/radius_centroid_tracker_top_assert.svh @@
// Assertion macros used by the tracker back end (rct_back).
// Expects signals named clk and rst in the scope that uses them.
`ifndef RADIUS_CENTROID_TRACKER_TOP_ASSERT_SVH
`define RADIUS_CENTROID_TRACKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define RCT_ASSERT(lbl, prop, msg)
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/rct_pkg.sv @@
// Types and constants shared by the radius centroid tracker.
// No dependencies; every other RTL module imports this package.
package rct_pkg;

  localparam int COORD_W        = 20;
  localparam int AXES           = 3;
  localparam int RADIUS_W       = 42;
  localparam int CFG_W          = 42;
  localparam int CFG_IDX_W      = 2;
  localparam int COUNT_OUT_W    = 17;
  localparam int MAX_POINTS_DEF = 65536;
  localparam int QUEUE_DEPTH    = 4;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int D2_W   = 2 * COORD_W + 2;

  // Reset values: 0.5 m radius squared, start at (-9.45, -4.82, -0.71) m.
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(262144);
  localparam logic [COORD_W-1:0]  START_X_RST = COORD_W'(-9677);
  localparam logic [COORD_W-1:0]  START_Y_RST = COORD_W'(-4936);
  localparam logic [COORD_W-1:0]  START_Z_RST = COORD_W'(-727);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_WAIT,
    ST_START,
    ST_DIV,
    ST_PUT
  } back_state_t;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] p;
    logic                         last;
  } point_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

@@ rtl/rct_front.sv @@
// Input side of the tracker: accepts points, tags the frame end and
// buffers them in a short register queue. Depends on rct_pkg.
module rct_front import rct_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      point_valid,
  output logic                      point_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      frame_end,
  output logic                      head_valid,
  output point_t                    head,
  input  logic                      pop
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  point_t            entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  point_t            incoming;

  assign point_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign head_valid  = (fill != '0);
  assign head        = entry[rd_ptr];
  assign push        = point_valid && point_ready;

  always_comb begin
    incoming.p[0] = point_x;
    incoming.p[1] = point_y;
    incoming.p[2] = point_z;
    incoming.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

@@ rtl/rct_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-axis mean.
// The caller guarantees the quotient fits in QUOT_W bits. Depends on rct_pkg.
module rct_div import rct_pkg::*; #(
  parameter int NUM_W  = COORD_W + 17,
  parameter int DEN_W  = 17,
  parameter int QUOT_W = COORD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  rem_next;
  logic [DEN_W:0]    trial;
  logic [QUOT_W-1:0] q;
  logic [STEP_W-1:0] steps;
  logic              qbit;

  // The upper dividend bits start out below the divisor, so only the low
  // QUOT_W bits need a step each.
  always_comb begin
    trial    = {rem, q[QUOT_W-1]};
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(num >> QUOT_W);
      q   <= num[QUOT_W-1:0];
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[QUOT_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(QUOT_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end
  end

  assign busy = (steps != '0);
  assign quot = q;

endmodule

@@ rtl/rct_back.sv @@
// Execution side of the tracker: distance pipeline, accumulation, mean
// division, tracked position and the result register.
// Depends on rct_pkg, rct_div and the assertion macro header.
`include "radius_centroid_tracker_top_assert.svh"

module rct_back import rct_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_wr_t                       cfg,
  input  logic                          head_valid,
  input  point_t                        head,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          found,
  output logic signed [COORD_W-1:0]     track_x,
  output logic signed [COORD_W-1:0]     track_y,
  output logic signed [COORD_W-1:0]     track_z,
  output logic        [COUNT_OUT_W-1:0] matched_count,
  output logic                          count_overflow
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + CNT_W;

  back_state_t state, state_next;

  logic        [RADIUS_W-1:0] radius_squared;
  logic signed [COORD_W-1:0]  tracked [AXES];

  logic                        a_valid, a_last;
  logic signed [COORD_W-1:0]   a_p [AXES];
  logic signed [DIFF_W-1:0]    a_d [AXES];
  logic signed [2*DIFF_W-1:0]  prod [AXES];

  logic                        b_valid, b_last;
  logic signed [COORD_W-1:0]   b_p [AXES];
  logic        [SQ_W-1:0]      b_sq [AXES];

  logic                        c_valid, c_last;
  logic signed [COORD_W-1:0]   c_p [AXES];
  logic        [D2_W-1:0]      c_d2;
  logic                        match;

  logic signed [SUM_W-1:0]     sum [AXES];
  logic        [SUM_W-1:0]     mag [AXES];
  logic        [CNT_W-1:0]     count;
  logic                        overflow_seen;

  logic                        div_start;
  logic        [AXES-1:0]      div_busy;
  logic        [COORD_W-1:0]   quot [AXES];
  logic signed [COORD_W-1:0]   mean [AXES];
  logic                        load_result;
  logic                        any_found;

  assign pop       = (state == ST_RUN) && head_valid;
  assign match     = (c_d2 <= D2_W'(radius_squared));
  assign any_found = (count != '0);

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prod[i] = a_d[i] * a_d[i];
      mag[i]  = sum[i][SUM_W-1] ? (~sum[i] + SUM_W'(1)) : sum[i];
      mean[i] = sum[i][SUM_W-1] ? (~quot[i] + COORD_W'(1)) : quot[i];
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_div
    rct_div #(
      .NUM_W  (SUM_W),
      .DEN_W  (CNT_W),
      .QUOT_W (COORD_W)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (mag[g]),
      .den   (count),
      .busy  (div_busy[g]),
      .quot  (quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (pop && head.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (c_valid && c_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        div_start  = any_found;
        state_next = any_found ? ST_DIV : ST_PUT;
      end
      ST_DIV: begin
        if (div_busy == '0) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Distance pipeline payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      a_p[i] <= $signed(head.p[i]);
      a_d[i] <= {head.p[i][COORD_W-1], head.p[i]} - {tracked[i][COORD_W-1], tracked[i]};
      b_p[i] <= a_p[i];
      b_sq[i] <= SQ_W'(prod[i]);
      c_p[i] <= b_p[i];
    end
    a_last <= head.last;
    b_last <= a_last;
    c_last <= b_last;
    c_d2   <= D2_W'(b_sq[0]) + D2_W'(b_sq[1]) + D2_W'(b_sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
      count          <= '0;
      overflow_seen  <= 1'b0;
      result_valid   <= 1'b0;
      radius_squared <= RADIUS_RST;
      tracked[0]     <= START_X_RST;
      tracked[1]     <= START_Y_RST;
      tracked[2]     <= START_Z_RST;
      for (int i = 0; i < AXES; i++) begin
        sum[i] <= '0;
      end
    end else begin
      a_valid <= pop;
      b_valid <= a_valid;
      c_valid <= b_valid;

      if (c_valid && match) begin
        if (count < CNT_W'(MAX_POINTS)) begin
          for (int i = 0; i < AXES; i++) begin
            sum[i] <= sum[i] + {{CNT_W{c_p[i][COORD_W-1]}}, c_p[i]};
          end
          count <= count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      if (load_result) begin
        result_valid <= 1'b1;
        for (int i = 0; i < AXES; i++) begin
          sum[i] <= '0;
          if (any_found) begin
            tracked[i] <= mean[i];
          end
        end
        count         <= '0;
        overflow_seen <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (cfg.we) begin
        unique case (reg_idx_t'(cfg.index))
          REG_RADIUS:  radius_squared <= RADIUS_W'(cfg.data);
          REG_START_X: tracked[0] <= cfg.data[COORD_W-1:0];
          REG_START_Y: tracked[1] <= cfg.data[COORD_W-1:0];
          REG_START_Z: tracked[2] <= cfg.data[COORD_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      found          <= any_found;
      track_x        <= any_found ? mean[0] : tracked[0];
      track_y        <= any_found ? mean[1] : tracked[1];
      track_z        <= any_found ? mean[2] : tracked[2];
      matched_count  <= COUNT_OUT_W'(count);
      count_overflow <= overflow_seen;
    end
  end

  `RCT_ASSERT_NEXT(a_last_blocks_pop, (pop && head.last), !pop, "pop after frame end")
  `RCT_ASSERT(a_count_bounded, (count <= CNT_W'(MAX_POINTS)), "match count beyond maximum")
  `RCT_ASSERT(a_div_in_div_state, ((div_busy != '0) |-> (state == ST_DIV)), "divider busy outside division")
  `RCT_ASSERT(a_pipe_empty_at_put, ((state == ST_PUT) |-> !(a_valid || b_valid || c_valid)), "points in flight at result")

endmodule

@@ rtl/radius_centroid_tracker_top.sv @@
// Radius centroid tracker: flat-kernel mean-shift tracking of one object.
// Throughput: one point per cycle inside a frame; after a frame end the back end pauses
// until its result is loaded, while the four-entry queue keeps taking points.
// Result path: once a frame end's last point leaves the distance pipeline, the 20-step
// mean divider runs (skipped when nothing matched) before the result register loads.
// Reset (synchronous, active high) loads defaults and clears sums, count, queue and result valid.
module radius_centroid_tracker_top import rct_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic        [CFG_IDX_W-1:0]   cfg_index,
  input  logic        [CFG_W-1:0]       cfg_data,
  input  logic                          point_valid,
  output logic                          point_ready,
  input  logic signed [COORD_W-1:0]     point_x,
  input  logic signed [COORD_W-1:0]     point_y,
  input  logic signed [COORD_W-1:0]     point_z,
  input  logic                          frame_end,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          found,
  output logic signed [COORD_W-1:0]     track_x,
  output logic signed [COORD_W-1:0]     track_y,
  output logic signed [COORD_W-1:0]     track_z,
  output logic        [COUNT_OUT_W-1:0] matched_count,
  output logic                          count_overflow
);

  // The front end only buffers points; all arithmetic lives in the back end.
  // Because the next frame's distances need the new mean, the back end stops
  // popping after a frame end until its result is in the output register,
  // while the front queue keeps accepting transfers until it fills.

  cfg_wr_t cfg;
  point_t  head;
  logic    head_valid;
  logic    pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .frame_end   (frame_end),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  // The back end also owns the result register, so a finished result can
  // wait for its transfer while the next frame's points are queued.
  rct_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .found          (found),
    .track_x        (track_x),
    .track_y        (track_y),
    .track_z        (track_z),
    .matched_count  (matched_count),
    .count_overflow (count_overflow)
  );

endmodule
